// ===== sv/object_pool_allocator_defines.svh =====
// assertion macros for the object pool allocator checker
// no dependencies; included by files that hold assertions
`ifndef OBJECT_POOL_ALLOCATOR_DEFINES_SVH
`define OBJECT_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled while rst is high
`define OPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define OPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/opa_pkg.sv =====
// shared types, codes and sizes for the object pool allocator
// no dependencies; used by every module of the block except opa_ram
package opa_pkg;

   localparam int POOL_SIZE = 64;
   localparam int HANDLE_W  = 6;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int IDX_W     = $clog2(POOL_SIZE);
   localparam int COUNT_W   = $clog2(POOL_SIZE + 1);

   // request kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TRY   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;

   // classified operations handed from front to back
   typedef logic [2:0] op_type;
   localparam op_type OP_NOP    = 3'd0;
   localparam op_type OP_ALLOC  = 3'd1;
   localparam op_type OP_TRY    = 3'd2;
   localparam op_type OP_FREE   = 3'd3;
   localparam op_type OP_REJECT = 3'd4;

   typedef struct packed {
      op_type              op;
      logic [HANDLE_W-1:0] handle;
   } cmd_type;

endpackage

// ===== sv/opa_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module opa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/opa_front.sv =====
// front end: accepts request words, classifies them, holds a two-deep command queue
// depends on opa_pkg
module opa_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [opa_pkg::KIND_W-1:0]      req_kind,
   input  logic [opa_pkg::HANDLE_W-1:0]    req_handle,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output opa_pkg::cmd_type                cmd
);

   opa_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   opa_pkg::cmd_type cls;
   logic             push, pop;

   // classify the incoming word
   always_comb begin
      cls.handle = req_handle;
      case (req_kind)
         opa_pkg::KIND_ALLOC: cls.op = opa_pkg::OP_ALLOC;
         opa_pkg::KIND_TRY:   cls.op = opa_pkg::OP_TRY;
         opa_pkg::KIND_FREE: begin
            if (32'(req_handle) < opa_pkg::POOL_SIZE) begin
               cls.op = opa_pkg::OP_FREE;
            end else begin
               cls.op = opa_pkg::OP_REJECT;
            end
         end
         default:             cls.op = opa_pkg::OP_NOP;
      endcase
   end

   // queue handshake
   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue entries
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== sv/opa_back.sv =====
// back end: carries out commands against the free list, fresh counter and in-use map
// depends on opa_pkg and opa_ram
module opa_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  opa_pkg::cmd_type                cmd,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [opa_pkg::HANDLE_W-1:0]    rsp_granted_handle,
   output logic [opa_pkg::STATUS_W-1:0]    rsp_status
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                           state_ff, state_in;
   logic [opa_pkg::IDX_W-1:0]      head_ff, head_in;
   logic [opa_pkg::IDX_W-1:0]      tail_ff, tail_in;
   logic [opa_pkg::COUNT_W-1:0]    qcount_ff, qcount_in;
   logic [opa_pkg::COUNT_W-1:0]    fresh_ff, fresh_in;
   logic [opa_pkg::POOL_SIZE-1:0]  map_ff, map_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [opa_pkg::HANDLE_W-1:0]   grant_ff, grant_in;
   logic [opa_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic                           out_free;
   logic                           ram_we, ram_re;
   logic [opa_pkg::HANDLE_W-1:0]   ram_rd_data;

   localparam logic [opa_pkg::IDX_W-1:0]   LAST_IDX = opa_pkg::IDX_W'(opa_pkg::POOL_SIZE - 1);
   localparam logic [opa_pkg::COUNT_W-1:0] FULL_CNT = opa_pkg::COUNT_W'(opa_pkg::POOL_SIZE);

   // released handles in fifo order
   opa_ram #(
      .WIDTH (opa_pkg::HANDLE_W),
      .DEPTH (opa_pkg::POOL_SIZE)
   ) u_free_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (cmd.handle),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      qcount_in    = qcount_ff;
      fresh_in     = fresh_ff;
      map_in       = map_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      grant_in     = grant_ff;
      status_in    = status_ff;
      cmd_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready    = 1'b1;
               rsp_valid_in = 1'b1;
               grant_in     = '0;
               status_in    = opa_pkg::ST_OK;
               case (cmd.op)
                  opa_pkg::OP_ALLOC, opa_pkg::OP_TRY: begin
                     if (qcount_ff != '0) begin
                        // pop oldest released handle; data comes back next cycle
                        ram_re       = 1'b1;
                        head_in      = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
                        qcount_in    = qcount_ff - 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_READ;
                     end else if (cmd.op == opa_pkg::OP_ALLOC && fresh_ff < FULL_CNT) begin
                        // never-used handle
                        grant_in = opa_pkg::HANDLE_W'(fresh_ff);
                        map_in[opa_pkg::HANDLE_W'(fresh_ff)] = 1'b1;
                        fresh_in = fresh_ff + 1'b1;
                     end else begin
                        status_in = opa_pkg::ST_NONE;
                     end
                  end
                  opa_pkg::OP_FREE: begin
                     if (map_ff[cmd.handle] && qcount_ff < FULL_CNT) begin
                        map_in[cmd.handle] = 1'b0;
                        ram_we    = 1'b1;
                        tail_in   = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
                        qcount_in = qcount_ff + 1'b1;
                     end else begin
                        status_in = opa_pkg::ST_NOT_ALLOC;
                     end
                  end
                  opa_pkg::OP_REJECT: status_in = opa_pkg::ST_NOT_ALLOC;
                  default:            status_in = opa_pkg::ST_OK;
               endcase
            end
         end
         ST_READ: begin
            // output register is empty here: it was free when the pop issued
            rsp_valid_in          = 1'b1;
            grant_in              = ram_rd_data;
            status_in             = opa_pkg::ST_OK;
            map_in[ram_rd_data]   = 1'b1;
            state_in              = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         qcount_ff    <= '0;
         fresh_ff     <= '0;
         map_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         qcount_ff    <= qcount_in;
         fresh_ff     <= fresh_in;
         map_ff       <= map_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      grant_ff  <= grant_in;
      status_ff <= status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_handle = grant_ff;
   assign rsp_status         = status_ff;

endmodule

// ===== sv/object_pool_allocator.sv =====
// top level of the object pool allocator: front end, command queue and back end
// depends on opa_pkg, opa_front, opa_back
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_ready  req_kind, req_handle
//   rsp       out         rsp_valid / rsp_ready  rsp_granted_handle, rsp_status
//
// the front takes one word a cycle while the queue has room, into a two-deep command queue.
// the back carries out a command from idle; an allocation from the released-handle
// fifo also passes a read state, for the registered read port of the fifo ram.
// reset clears counters, pointers and the in-use bitmap directly; no clearing pass.
// a result waits in the output register until taken; the queue keeps filling meanwhile.
module object_pool_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [opa_pkg::KIND_W-1:0]      req_kind,
   input  logic [opa_pkg::HANDLE_W-1:0]    req_handle,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [opa_pkg::HANDLE_W-1:0]    rsp_granted_handle,
   output logic [opa_pkg::STATUS_W-1:0]    rsp_status
);

   logic             cmd_valid;
   logic             cmd_ready;
   opa_pkg::cmd_type cmd;

   // accept and classify
   opa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_kind   (req_kind),
      .req_handle (req_handle),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   // execute
   opa_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd_ready          (cmd_ready),
      .cmd                (cmd),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_granted_handle (rsp_granted_handle),
      .rsp_status         (rsp_status)
   );

endmodule

// ===== sv/opa_checker.sv =====
// port-level checks for the object pool allocator, bound to the top level
// depends on opa_pkg and object_pool_allocator_defines.svh
`include "object_pool_allocator_defines.svh"

module opa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [opa_pkg::HANDLE_W-1:0]    rsp_granted_handle,
   input logic [opa_pkg::STATUS_W-1:0]    rsp_status
);

   // a stalled result word holds
   `OPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_granted_handle) && $stable(rsp_status), "rsp word changed while stalled")

   // failures never carry a handle
   `OPA_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && rsp_status != opa_pkg::ST_OK, rsp_granted_handle == '0, "failed response carries a handle")

   // only defined status codes leave the block
   `OPA_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status == opa_pkg::ST_OK || rsp_status == opa_pkg::ST_NONE || rsp_status == opa_pkg::ST_NOT_ALLOC, "undefined status code")

   // no result right after reset
   `OPA_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "response valid right after reset")

endmodule

bind object_pool_allocator opa_checker u_checker (.*);
